/* src/vpd_pkg.sv */
// Shared constants, tables and stage payload types for the vapor pressure
// deficit datapath. No dependencies.
`default_nettype none
package vpd_pkg;

  localparam int TEMP_W = 12;
  localparam int HUM_W  = 10;
  localparam int DEF_W  = 18;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam int FRAC  = 28;
  localparam int Q_W   = 31;   // quotient bits of the exponent division
  localparam int DEN_W = 19;
  localparam int NUM_W = 51;
  localparam int X_W   = 32;
  localparam int R_W   = 28;
  localparam int T_W   = 29;   // series term, first term is 1.0
  localparam int E_W   = 30;
  localparam int K_W   = 4;
  localparam int C_W   = 26;
  localparam int P_W   = 56;
  localparam int Y_W   = 36;
  localparam int V_W   = 30;
  localparam int M_W   = 61;
  localparam int TERMS = 12;
  localparam int K_BIAS = 6;
  localparam int SHIFT_BASE = FRAC + K_BIAS;
  localparam int RECIP_SHIFT = 32;
  localparam int DIV_SHIFT   = 42;

  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -12'sd400;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 12'sd1250;
  localparam logic [HUM_W-1:0] HUM_MAX = 10'd1000;

  localparam logic [X_W-1:0] LN2    = 32'd186065279;
  localparam logic [X_W-1:0] X_BIAS = 32'd1116391674;   // K_BIAS * LN2
  localparam logic [T_W-1:0] ONE_Q  = 29'h1000_0000;
  localparam logic [15:0]    SAT_PA = 16'd61078;
  localparam logic [30:0]    RECIP_3125 = 31'd1407374884;
  localparam logic [Y_W-1:0] ROUND_HALF = 36'd50000;
  localparam logic [DEF_W-1:0] OUT_MAX = 18'h3FFFF;

  // ceil(2^32 / i) for series divisors 1..12; entry for 1 is a bypass
  localparam logic [31:0] RECIP [TERMS] = '{
    32'd0,          32'd2147483648, 32'd1431655766, 32'd1073741824,
    32'd858993460,  32'd715827883,  32'd613566757,  32'd536870912,
    32'd477218589,  32'd429496730,  32'd390451573,  32'd357913942
  };

  typedef struct packed {
    logic [Q_W-1:0]   q;
    logic             neg;
    logic [HUM_W-1:0] hum;
  } div_out_t;

  typedef struct packed {
    logic [E_W-1:0]   e;
    logic [K_W-1:0]   kb;
    logic [HUM_W-1:0] hum;
  } exp_out_t;

endpackage
`default_nettype wire

/* src/vapor_pressure_deficit_core.sv */
// Vapor pressure deficit core: one sample in, one result out, fully pipelined.
// Slave stream s_axis_* carries temperature and humidity, master stream
// m_axis_* carries the deficit in pascals.
// A sample passes through the divider, range reduction and the series, final
// scaling and the output register, in that order.
// Throughput: one transfer per cycle unless stalled; every stage is a pipeline register.
// An output register plus one skid entry let the pipeline run while a result
// waits; when the receiver stalls and the skid entry fills, the whole
// pipeline holds and s_axis_tready drops, so nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; data registers are not
// cleared. Temperature is clamped to -40.0..125.0 C and humidity to 100.0%.
// Depends on vpd_pkg, vpd_div, vpd_exp, vpd_scale.
`default_nettype none
module vapor_pressure_deficit_core
  import vpd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // temperature[11:0], humidity[21:12]
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // deficit_pa[17:0]
);

  logic en;
  logic in_valid;
  logic div_valid, exp_valid, sc_valid;
  div_out_t div_out;
  exp_out_t exp_out;
  logic [DEF_W-1:0] sc_deficit;

  logic             out_valid, skid_valid;
  logic [DEF_W-1:0] out_data, skid_data;

  assign en = !skid_valid;
  assign s_axis_tready = en;
  assign in_valid = s_axis_tvalid;

  vpd_div u_div (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (in_valid),
    .temperature (signed'(s_axis_tdata[TEMP_W-1:0])),
    .humidity    (s_axis_tdata[TEMP_W+HUM_W-1:TEMP_W]),
    .out_valid   (div_valid),
    .out         (div_out)
  );

  vpd_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .in        (div_out),
    .out_valid (exp_valid),
    .out       (exp_out)
  );

  vpd_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (exp_valid),
    .in         (exp_out),
    .out_valid  (sc_valid),
    .deficit_pa (sc_deficit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= sc_valid;
        out_data  <= sc_deficit;
      end
    end else if (en && sc_valid) begin
      // output held: park the result leaving the pipeline
      skid_valid <= 1'b1;
      skid_data  <= sc_deficit;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-DEF_W){1'b0}}, out_data};

endmodule
`default_nettype wire

/* src/vpd_div.sv */
// Input clamp and pipelined restoring divider for 17.27*T/(T+237.3) in Q28.
// Depends on vpd_pkg.
`default_nettype none
module vpd_div
  import vpd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic signed [TEMP_W-1:0] temperature,
  input  wire logic [HUM_W-1:0]         humidity,
  output logic                          out_valid,
  output div_out_t                      out
);

  logic signed [TEMP_W-1:0] t_c;
  logic [HUM_W-1:0]  h_c;
  logic [10:0]       mag;
  logic signed [12:0] t_sum;
  logic [11:0]       tb;
  logic [DEN_W-1:0]  den_in;
  logic [17:0]       half_in;
  logic [21:0]       prod_in;
  logic [NUM_W-1:0]  num_in;

  always_comb begin
    if (temperature < TEMP_MIN) begin
      t_c = TEMP_MIN;
    end else if (temperature > TEMP_MAX) begin
      t_c = TEMP_MAX;
    end else begin
      t_c = temperature;
    end
    h_c = (humidity > HUM_MAX) ? HUM_MAX : humidity;
    mag = t_c[TEMP_W-1] ? 11'(-t_c) : 11'(t_c);
    t_sum = {t_c[TEMP_W-1], t_c} + 13'sd2373;
    tb = t_sum[11:0];
    den_in = 19'(19'(tb) * 19'd100);
    half_in = 18'(18'(tb) * 18'd50);
    prod_in = 22'(mag) * 22'd1727;
    num_in = {1'b0, prod_in, 28'b0} + NUM_W'(half_in);
  end

  logic [DEN_W-1:0]  rem  [Q_W+1];
  logic [Q_W-1:0]    nlo  [Q_W+1];
  logic [Q_W-1:0]    quo  [Q_W+1];
  logic [DEN_W-1:0]  den  [Q_W+1];
  logic              neg  [Q_W+1];
  logic [HUM_W-1:0]  hum  [Q_W+1];
  logic              vld  [Q_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      rem[0] <= num_in[NUM_W-2:Q_W];
      nlo[0] <= num_in[Q_W-1:0];
      quo[0] <= '0;
      den[0] <= den_in;
      neg[0] <= t_c[TEMP_W-1];
      hum[0] <= h_c;
    end
  end

  for (genvar s = 1; s <= Q_W; s++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem[s-1], nlo[s-1][Q_W-1]};
    assign ge    = trial >= {1'b0, den[s-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
      if (en) begin
        rem[s] <= ge ? DEN_W'(trial - {1'b0, den[s-1]}) : trial[DEN_W-1:0];
        nlo[s] <= {nlo[s-1][Q_W-2:0], 1'b0};
        quo[s] <= {quo[s-1][Q_W-2:0], ge};
        den[s] <= den[s-1];
        neg[s] <= neg[s-1];
        hum[s] <= hum[s-1];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign out.q     = quo[Q_W];
  assign out.neg   = neg[Q_W];
  assign out.hum   = hum[Q_W];

endmodule
`default_nettype wire

/* src/vpd_exp.sv */
// Range reduction by ln 2 and a pipelined 12-term series for exp(r) in Q28.
// Depends on vpd_pkg.
`default_nettype none
module vpd_exp
  import vpd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  wire div_out_t in,
  output logic          out_valid,
  output exp_out_t      out
);

  // biased exponent is never negative: x + 6*ln2
  logic [X_W-1:0]   xr  [K_W];
  logic [K_W-1:0]   kr  [K_W];
  logic [HUM_W-1:0] hr  [K_W];
  logic             vr  [K_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vr[0] <= 1'b0;
    end else if (en) begin
      vr[0] <= in_valid;
    end
    if (en) begin
      xr[0] <= in.neg ? X_BIAS - {1'b0, in.q} : X_BIAS + {1'b0, in.q};
      kr[0] <= '0;
      hr[0] <= in.hum;
    end
  end

  for (genvar b = 1; b < K_W; b++) begin : g_red
    localparam logic [X_W-1:0] W = LN2 << (K_W - b);
    logic ge;
    assign ge = xr[b-1] >= W;
    always_ff @(posedge clk) begin
      if (rst) begin
        vr[b] <= 1'b0;
      end else if (en) begin
        vr[b] <= vr[b-1];
      end
      if (en) begin
        xr[b] <= ge ? xr[b-1] - W : xr[b-1];
        kr[b] <= {kr[b-1][K_W-2:0], ge};
        hr[b] <= hr[b-1];
      end
    end
  end

  // series nodes: index 0 is the reduced value, i is after term i
  logic [R_W-1:0]   rs  [TERMS+1];
  logic [K_W-1:0]   ks  [TERMS+1];
  logic [HUM_W-1:0] hs  [TERMS+1];
  logic             vs  [TERMS+1];
  logic [T_W-1:0]   term[TERMS+1];
  logic [E_W-1:0]   es  [TERMS+1];

  logic ge_last;
  assign ge_last = xr[K_W-1] >= LN2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= vr[K_W-1];
    end
    if (en) begin
      rs[0] <= ge_last ? R_W'(xr[K_W-1] - LN2) : xr[K_W-1][R_W-1:0];
      ks[0] <= {kr[K_W-1][K_W-2:0], ge_last};
      hs[0] <= hr[K_W-1];
    end
  end

  assign term[0] = ONE_Q;
  assign es[0]   = E_W'(ONE_Q);

  for (genvar i = 1; i <= TERMS; i++) begin : g_term
    logic [R_W-1:0]   va;
    logic [R_W-1:0]   ra;
    logic [K_W-1:0]   ka;
    logic [HUM_W-1:0] ha;
    logic [E_W-1:0]   ea;
    logic             vla;
    logic [T_W+R_W-1:0] prod;
    logic [R_W+31:0]    qprod;
    logic [T_W-1:0]     tnext;

    assign prod = (T_W+R_W)'(term[i-1]) * (T_W+R_W)'(rs[i-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vla <= 1'b0;
      end else if (en) begin
        vla <= vs[i-1];
      end
      if (en) begin
        va <= prod[FRAC+R_W-1:FRAC];
        ra <= rs[i-1];
        ka <= ks[i-1];
        ha <= hs[i-1];
        ea <= es[i-1];
      end
    end

    // floor(v / i) by reciprocal, exact for v below 2^28
    assign qprod = (R_W+32)'(va) * (R_W+32)'(RECIP[i-1]);
    if (i == 1) begin : g_pass
      assign tnext = T_W'(va);
    end else begin : g_recip
      assign tnext = T_W'(qprod[R_W+31:RECIP_SHIFT]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i] <= 1'b0;
      end else if (en) begin
        vs[i] <= vla;
      end
      if (en) begin
        term[i] <= tnext;
        es[i]   <= ea + E_W'(tnext);
        rs[i]   <= ra;
        ks[i]   <= ka;
        hs[i]   <= ha;
      end
    end
  end

  assign out_valid = vs[TERMS];
  assign out.e     = es[TERMS];
  assign out.kb    = ks[TERMS];
  assign out.hum   = hs[TERMS];

endmodule
`default_nettype wire

/* src/vpd_scale.sv */
// Scaling by saturation pressure and dryness, power of two, and rounded
// division down to pascals. Depends on vpd_pkg.
`default_nettype none
module vpd_scale
  import vpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire exp_out_t    in,
  output logic             out_valid,
  output logic [DEF_W-1:0] deficit_pa
);

  logic             v1, v2, v3, v4, v5;
  logic [C_W-1:0]   c1;
  logic [E_W-1:0]   e1;
  logic [K_W-1:0]   k1, k2;
  logic [P_W-1:0]   p2;
  logic [V_W-1:0]   z3;
  logic [M_W-1:0]   m4;
  logic [DEF_W-1:0] d5;

  logic [5:0]     sh;
  logic [P_W-1:0] p_sh;
  logic [Y_W-1:0] y_r;
  logic [M_W-DIV_SHIFT-1:0] q19;

  always_comb begin
    sh   = 6'(SHIFT_BASE) - 6'(k2);
    p_sh = p2 >> sh;
    y_r  = p_sh[Y_W-1:0] + ROUND_HALF;
    q19  = m4[M_W-1:DIV_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    if (en) begin
      c1 <= C_W'(C_W'(HUM_MAX - in.hum) * C_W'(SAT_PA));
      e1 <= in.e;
      k1 <= in.kb;
      p2 <= P_W'(e1) * P_W'(c1);
      k2 <= k1;
      // divide by 100000 as a shift by 5 and a divide by 3125
      z3 <= y_r[V_W+4:5];
      m4 <= M_W'(z3) * M_W'(RECIP_3125);
      d5 <= (q19 > M_W'(OUT_MAX)) ? OUT_MAX : q19[DEF_W-1:0];
    end
  end

  assign out_valid  = v5;
  assign deficit_pa = d5;

endmodule
`default_nettype wire

/* src/vpd_checker.sv */
// Port-level checks for the vapor pressure deficit core, bound to the top.
// Depends on vpd_pkg and vapor_pressure_deficit_core.
`default_nettype none
module vpd_checker
  import vpd_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled transfer changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:DEF_W] == '0 &&
                      m_axis_tdata[DEF_W-1:0] <= 18'd245000)
    else $error("deficit out of range");

endmodule

bind vapor_pressure_deficit_core vpd_checker u_vpd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
